/* hdl/gamepad_poll_serial_master_macros.svh */
// ============================================================================
// Gamepad poll serial master: assertion macros
// Concurrent assertion wrappers clocked on aclk. Both compile away when
// SYNTHESIS is defined.
// ============================================================================
`ifndef GAMEPAD_POLL_SERIAL_MASTER_MACROS_SVH
`define GAMEPAD_POLL_SERIAL_MASTER_MACROS_SVH

`ifndef SYNTHESIS

// Property checked only while the block is out of reset.
`define GPSM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("gamepad poll master check failed");

// Property checked on every clock edge, reset included.
`define GPSM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("gamepad poll master check failed");

`else

`define GPSM_ASSERT(lbl, prop)
`define GPSM_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

/* hdl/gpsm_pkg.sv */
// ============================================================================
// Gamepad poll serial master package
// Word types, register map, protocol constants and the command byte lookup.
// ============================================================================
package gpsm_pkg;

    // Number of bytes exchanged in one poll.
    localparam int PACKET_BYTES = 9;

    // Byte position counter must hold PACKET_BYTES and feed a 4-bit index.
    localparam int BYTE_POS_W = ($clog2(PACKET_BYTES + 1) > 4) ?
                                $clog2(PACKET_BYTES + 1) : 4;

    localparam int TICK_W     = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SETUP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_PRE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_LEAD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_POST   = 3'd5;

    // Register reset values.
    localparam logic [7:0]        RST_SETUP      = 8'd5;
    localparam logic [7:0]        RST_CLOCK_LOW  = 8'd16;
    localparam logic [7:0]        RST_CLOCK_HIGH = 8'd16;
    localparam logic [TICK_W-1:0] RST_SEL_PRE    = 10'd100;
    localparam logic [7:0]        RST_SEL_LEAD   = 8'd50;
    localparam logic [TICK_W-1:0] RST_SEL_POST   = 10'd100;

    // Input word kinds.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // Protocol bytes.
    localparam logic [7:0] CMD_START  = 8'h01;
    localparam logic [7:0] CMD_POLL   = 8'h42;
    localparam logic [7:0] CMD_FILL   = 8'h00;
    localparam logic [7:0] ID_MARKER  = 8'h5A;
    localparam int         MARKER_POS = 2;

    // Poll sequencer phases.
    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_PRE   = 7'b0000010,
        PH_LEAD  = 7'b0000100,
        PH_SETUP = 7'b0001000,
        PH_LOW   = 7'b0010000,
        PH_HIGH  = 7'b0100000,
        PH_POST  = 7'b1000000
    } gpsm_phase_t;

    typedef struct packed {
        logic kind;
        logic dat_in;
    } gpsm_in_t;

    typedef struct packed {
        logic       clk_level;
        logic       cmd_level;
        logic       sel_level;
        logic       busy_res;
        logic       byte_valid;
        logic [3:0] byte_index;
        logic [7:0] byte_value;
        logic       packet_done;
        logic       packet_ok;
    } gpsm_out_t;

    // Command bit sent at a given byte position and bit position.
    function automatic logic gpsm_cmd_bit(input logic [BYTE_POS_W-1:0] pos,
                                          input logic [2:0]            bit_idx);
        logic [7:0] cmd;
        if (pos == BYTE_POS_W'(0)) begin
            cmd = CMD_START;
        end else if (pos == BYTE_POS_W'(1)) begin
            cmd = CMD_POLL;
        end else begin
            cmd = CMD_FILL;
        end
        return cmd[bit_idx];
    endfunction

endpackage

/* hdl/gamepad_poll_serial_master.sv */
// ============================================================================
// Gamepad poll serial master
// Bit-banged poll sequencer for a gamepad serial link, timed by tick words.
// ============================================================================
// Usage:
// Each input word on s_data is either a one-microsecond tick or a start
// request. A start request while idle arms a poll; while busy it is ignored.
// Ticks step the sequencer: select pre wait, select lead wait, then for each
// bit a setup wait, a clock-low wait ending in a data sample and a clock-high
// wait, then a select post wait. The sampled data level rides in the tick word.
// Every accepted input word produces exactly one result word on m_data,
// carrying the pin levels, busy, any completed byte and the done/ok flags.
// The result is registered: it appears in the cycle after acceptance, and a
// new word is taken every cycle while m_ready is high. The whole update is a
// single combinational pass from the state registers into the result
// register. When the receiver stalls, the held result blocks input only once
// the output register is full; s_ready follows m_ready then. The user writes
// the timing registers through cfg_wr_en/cfg_index/cfg_wdata only while idle;
// the block does not enforce it. Reset restores the register defaults, idles
// the sequencer with all pins high and empties the output register.
// ============================================================================
`include "gamepad_poll_serial_master_macros.svh"

module gamepad_poll_serial_master (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input word channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  gpsm_pkg::gpsm_in_t             s_data,
    // Result word channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output gpsm_pkg::gpsm_out_t            m_data,
    // Configuration write port
    input  logic                           cfg_wr_en,
    input  logic [gpsm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gpsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import gpsm_pkg::*;

    // Timing registers
    logic [7:0]        setup_reg, clock_low_reg, clock_high_reg, sel_lead_reg;
    logic [TICK_W-1:0] sel_pre_reg, sel_post_reg;

    // Sequencer state
    gpsm_phase_t             phase_reg, phase_next;
    logic [TICK_W-1:0]       tick_reg, tick_next;
    logic [2:0]              bit_pos_reg, bit_pos_next;
    logic [BYTE_POS_W-1:0]   byte_pos_reg, byte_pos_next;
    logic [7:0]              shift_reg, shift_next;
    logic                    clk_out_reg, clk_out_next;
    logic                    cmd_out_reg, cmd_out_next;
    logic                    sel_out_reg, sel_out_next;
    logic                    marker_reg, marker_next;

    // Output register
    logic      m_valid_reg, m_valid_next;
    gpsm_out_t m_data_reg, m_data_next;

    logic                  in_fire;
    logic [TICK_W-1:0]     tick_inc;
    logic [TICK_W-1:0]     wait_len;
    logic                  wait_hit;
    logic [BYTE_POS_W-1:0] byte_inc;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_reg      <= RST_SETUP;
            clock_low_reg  <= RST_CLOCK_LOW;
            clock_high_reg <= RST_CLOCK_HIGH;
            sel_pre_reg    <= RST_SEL_PRE;
            sel_lead_reg   <= RST_SEL_LEAD;
            sel_post_reg   <= RST_SEL_POST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SETUP:      setup_reg      <= cfg_wdata[7:0];
                REG_CLOCK_LOW:  clock_low_reg  <= cfg_wdata[7:0];
                REG_CLOCK_HIGH: clock_high_reg <= cfg_wdata[7:0];
                REG_SEL_PRE:    sel_pre_reg    <= cfg_wdata;
                REG_SEL_LEAD:   sel_lead_reg   <= cfg_wdata[7:0];
                REG_SEL_POST:   sel_post_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Length of the wait belonging to the current phase.
    always_comb begin
        case (phase_reg)
            PH_PRE:   wait_len = sel_pre_reg;
            PH_LEAD:  wait_len = TICK_W'(sel_lead_reg);
            PH_SETUP: wait_len = TICK_W'(setup_reg);
            PH_LOW:   wait_len = TICK_W'(clock_low_reg);
            PH_HIGH:  wait_len = TICK_W'(clock_high_reg);
            PH_POST:  wait_len = sel_post_reg;
            default:  wait_len = '0;
        endcase
    end

    assign tick_inc = tick_reg + TICK_W'(1);
    assign wait_hit = (tick_inc >= wait_len);
    assign byte_inc = byte_pos_reg + BYTE_POS_W'(1);

    // Sequencer update and result word for one accepted input word.
    always_comb begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_pos_next  = bit_pos_reg;
        byte_pos_next = byte_pos_reg;
        shift_next    = shift_reg;
        clk_out_next  = clk_out_reg;
        cmd_out_next  = cmd_out_reg;
        sel_out_next  = sel_out_reg;
        marker_next   = marker_reg;

        m_data_next             = '0;

        if (s_data.kind == KIND_START) begin
            if (phase_reg == PH_IDLE) begin
                sel_out_next  = 1'b1;
                tick_next     = '0;
                bit_pos_next  = '0;
                byte_pos_next = '0;
                shift_next    = '0;
                marker_next   = 1'b0;
                phase_next    = PH_PRE;
            end
        end else begin
            // Every active phase counts ticks toward its wait length.
            if (phase_reg != PH_IDLE) begin
                tick_next = wait_hit ? '0 : tick_inc;
            end
            case (phase_reg)
                PH_IDLE: begin
                end
                PH_PRE: begin
                    if (wait_hit) begin
                        sel_out_next = 1'b0;
                        phase_next   = PH_LEAD;
                    end
                end
                PH_LEAD: begin
                    if (wait_hit) begin
                        cmd_out_next = gpsm_cmd_bit(byte_pos_reg, bit_pos_reg);
                        phase_next   = PH_SETUP;
                    end
                end
                PH_SETUP: begin
                    if (wait_hit) begin
                        clk_out_next = 1'b0;
                        phase_next   = PH_LOW;
                    end
                end
                PH_LOW: begin
                    // Sample the data line on the last clock-low tick.
                    if (wait_hit) begin
                        if (s_data.dat_in) begin
                            shift_next[bit_pos_reg] = 1'b1;
                        end
                        clk_out_next = 1'b1;
                        phase_next   = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    if (wait_hit) begin
                        if (bit_pos_reg == 3'd7) begin
                            m_data_next.byte_valid = 1'b1;
                            m_data_next.byte_index = byte_pos_reg[3:0];
                            m_data_next.byte_value = shift_reg;
                            if (byte_pos_reg == BYTE_POS_W'(MARKER_POS)) begin
                                marker_next = (shift_reg == ID_MARKER);
                            end
                            byte_pos_next = byte_inc;
                            bit_pos_next  = '0;
                            shift_next    = '0;
                            if (byte_inc >= BYTE_POS_W'(PACKET_BYTES)) begin
                                sel_out_next = 1'b1;
                                phase_next   = PH_POST;
                            end else begin
                                cmd_out_next = gpsm_cmd_bit(byte_inc, 3'd0);
                                phase_next   = PH_SETUP;
                            end
                        end else begin
                            bit_pos_next = bit_pos_reg + 3'd1;
                            cmd_out_next = gpsm_cmd_bit(byte_pos_reg,
                                                        bit_pos_reg + 3'd1);
                            phase_next   = PH_SETUP;
                        end
                    end
                end
                PH_POST: begin
                    if (wait_hit) begin
                        m_data_next.packet_done = 1'b1;
                        m_data_next.packet_ok   = marker_reg;
                        phase_next              = PH_IDLE;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        m_data_next.clk_level = clk_out_next;
        m_data_next.cmd_level = cmd_out_next;
        m_data_next.sel_level = sel_out_next;
        m_data_next.busy_res  = (phase_next != PH_IDLE);
    end

    // Output valid: set by an accepted word, cleared when the word is taken.
    always_comb begin
        if (in_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // State and output data registers advance only on an accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_pos_reg  <= '0;
            byte_pos_reg <= '0;
            shift_reg    <= '0;
            clk_out_reg  <= 1'b1;
            cmd_out_reg  <= 1'b1;
            sel_out_reg  <= 1'b1;
            marker_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (in_fire) begin
                phase_reg    <= phase_next;
                tick_reg     <= tick_next;
                bit_pos_reg  <= bit_pos_next;
                byte_pos_reg <= byte_pos_next;
                shift_reg    <= shift_next;
                clk_out_reg  <= clk_out_next;
                cmd_out_reg  <= cmd_out_next;
                sel_out_reg  <= sel_out_next;
                marker_reg   <= marker_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // A completed byte is always reported while the poll is still running.
    `GPSM_ASSERT(a_byte_while_busy, m_valid_reg && m_data_reg.byte_valid |-> m_data_reg.busy_res)

    // Done is reported on the word that returns the sequencer to idle.
    `GPSM_ASSERT(a_done_ends_poll, m_valid_reg && m_data_reg.packet_done |-> !m_data_reg.busy_res && (phase_reg == PH_IDLE))

    // The clock only goes low inside the select-low window.
    `GPSM_ASSERT(a_clock_low_in_window, (phase_reg == PH_LOW) |-> !clk_out_reg && !sel_out_reg)

    // Every accepted word leaves a result word in the output register.
    `GPSM_ASSERT(a_word_produces_result, s_valid && s_ready |=> m_valid_reg)

endmodule
